>>> design/ray_triangle_closest_hit_defines.svh
// Assertion helpers for the RTL file that checks itself.
`ifndef RAY_TRIANGLE_CLOSEST_HIT_DEFINES_SVH
`define RAY_TRIANGLE_CLOSEST_HIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RTC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked across reset.
`define RTC_ASSERT_AFTER(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/rtc_pkg.sv
`default_nettype none

package rtc_pkg;

  localparam int CW            = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int EW            = CW + 1;
  localparam int XW            = 2 * CW + 3;
  localparam int AW            = 3 * CW + 8;
  localparam int NUM_TERMS     = 24;
  localparam int TERM_IDX_W    = $clog2(NUM_TERMS);
  localparam int QUEUE_DEPTH   = 2;
  localparam int CFG_IDX_W     = 3;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [EW-1:0] edge_t;
  typedef logic signed [XW-1:0] xop_t;
  typedef logic signed [AW-1:0] acc_t;

  localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_ORIGIN_Z    = 3'd2,
    REG_DIRECTION_X = 3'd3,
    REG_DIRECTION_Y = 3'd4,
    REG_DIRECTION_Z = 3'd5,
    REG_NEAR_LIMIT  = 3'd6,
    REG_FAR_START   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    coord_t ray_origin_x;
    coord_t ray_origin_y;
    coord_t ray_origin_z;
    coord_t ray_direction_x;
    coord_t ray_direction_y;
    coord_t ray_direction_z;
    coord_t near_limit;
    coord_t far_limit_start;
  } ray_cfg_t;

  typedef struct packed {
    coord_t vertex_a_x;
    coord_t vertex_a_y;
    coord_t vertex_a_z;
    coord_t vertex_b_x;
    coord_t vertex_b_y;
    coord_t vertex_b_z;
    coord_t vertex_c_x;
    coord_t vertex_c_y;
    coord_t vertex_c_z;
    logic   new_ray;
  } in_beat_t;

  typedef struct packed {
    logic   hit;
    coord_t hit_distance;
    coord_t closest_distance;
  } out_beat_t;

  // Edges relative to vertex c, as queued between front and back.
  typedef struct packed {
    edge_t e1_x;
    edge_t e1_y;
    edge_t e1_z;
    edge_t e2_x;
    edge_t e2_y;
    edge_t e2_z;
    edge_t s_x;
    edge_t s_y;
    edge_t s_z;
    logic  new_ray;
  } edge_item_t;

  typedef enum logic [3:0] {
    XS_DIR_X, XS_DIR_Y, XS_DIR_Z,
    XS_S_X, XS_S_Y, XS_S_Z,
    XS_S1_X, XS_S1_Y, XS_S1_Z,
    XS_S2_X, XS_S2_Y, XS_S2_Z
  } xsel_t;

  typedef enum logic [3:0] {
    YS_E1_X, YS_E1_Y, YS_E1_Z,
    YS_E2_X, YS_E2_Y, YS_E2_Z,
    YS_S_X, YS_S_Y, YS_S_Z,
    YS_DIR_X, YS_DIR_Y, YS_DIR_Z
  } ysel_t;

  typedef enum logic [3:0] {
    DST_S1_X, DST_S1_Y, DST_S1_Z,
    DST_S2_X, DST_S2_Y, DST_S2_Z,
    DST_DET, DST_NT, DST_NB1, DST_NB2
  } dst_t;

  typedef struct packed {
    xsel_t xsel;
    ysel_t ysel;
    logic  neg;
    logic  last;
    dst_t  dst;
  } mac_term_t;

  function automatic edge_t ext_e(input coord_t v);
    return {v[CW-1], v};
  endfunction

  function automatic xop_t ext_x(input edge_t v);
    return {{(XW-EW){v[EW-1]}}, v};
  endfunction

  function automatic acc_t ext_a(input xop_t v);
    return {{(AW-XW){v[XW-1]}}, v};
  endfunction

  // Product program: s1 = dir x e2, s2 = s x e1, then det, nt, nb1, nb2.
  function automatic mac_term_t mac_prog(input logic [TERM_IDX_W-1:0] idx);
    mac_term_t t;
    case (idx)
      5'd0:  t = '{XS_DIR_Y, YS_E2_Z, 1'b0, 1'b0, DST_S1_X};
      5'd1:  t = '{XS_DIR_Z, YS_E2_Y, 1'b1, 1'b1, DST_S1_X};
      5'd2:  t = '{XS_DIR_Z, YS_E2_X, 1'b0, 1'b0, DST_S1_Y};
      5'd3:  t = '{XS_DIR_X, YS_E2_Z, 1'b1, 1'b1, DST_S1_Y};
      5'd4:  t = '{XS_DIR_X, YS_E2_Y, 1'b0, 1'b0, DST_S1_Z};
      5'd5:  t = '{XS_DIR_Y, YS_E2_X, 1'b1, 1'b1, DST_S1_Z};
      5'd6:  t = '{XS_S_Y, YS_E1_Z, 1'b0, 1'b0, DST_S2_X};
      5'd7:  t = '{XS_S_Z, YS_E1_Y, 1'b1, 1'b1, DST_S2_X};
      5'd8:  t = '{XS_S_Z, YS_E1_X, 1'b0, 1'b0, DST_S2_Y};
      5'd9:  t = '{XS_S_X, YS_E1_Z, 1'b1, 1'b1, DST_S2_Y};
      5'd10: t = '{XS_S_X, YS_E1_Y, 1'b0, 1'b0, DST_S2_Z};
      5'd11: t = '{XS_S_Y, YS_E1_X, 1'b1, 1'b1, DST_S2_Z};
      5'd12: t = '{XS_S1_X, YS_E1_X, 1'b0, 1'b0, DST_DET};
      5'd13: t = '{XS_S1_Y, YS_E1_Y, 1'b0, 1'b0, DST_DET};
      5'd14: t = '{XS_S1_Z, YS_E1_Z, 1'b0, 1'b1, DST_DET};
      5'd15: t = '{XS_S2_X, YS_E2_X, 1'b0, 1'b0, DST_NT};
      5'd16: t = '{XS_S2_Y, YS_E2_Y, 1'b0, 1'b0, DST_NT};
      5'd17: t = '{XS_S2_Z, YS_E2_Z, 1'b0, 1'b1, DST_NT};
      5'd18: t = '{XS_S1_X, YS_S_X, 1'b0, 1'b0, DST_NB1};
      5'd19: t = '{XS_S1_Y, YS_S_Y, 1'b0, 1'b0, DST_NB1};
      5'd20: t = '{XS_S1_Z, YS_S_Z, 1'b0, 1'b1, DST_NB1};
      5'd21: t = '{XS_S2_X, YS_DIR_X, 1'b0, 1'b0, DST_NB2};
      5'd22: t = '{XS_S2_Y, YS_DIR_Y, 1'b0, 1'b0, DST_NB2};
      5'd23: t = '{XS_S2_Z, YS_DIR_Z, 1'b0, 1'b1, DST_NB2};
      default: t = '{XS_DIR_X, YS_DIR_X, 1'b0, 1'b0, DST_NB2};
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> design/rtc_front.sv
`default_nettype none

module rtc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire rtc_pkg::in_beat_t  in_beat,
  input  wire rtc_pkg::ray_cfg_t  ray,
  output logic                    q_valid,
  input  wire logic               q_pop,
  output rtc_pkg::edge_item_t     q_item
);
  import rtc_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  edge_item_t       mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  edge_item_t       item_c;
  logic             wr_en;

  // Edges from vertex c, and the origin offset from c.
  always_comb begin
    item_c.e1_x    = ext_e(in_beat.vertex_a_x) - ext_e(in_beat.vertex_c_x);
    item_c.e1_y    = ext_e(in_beat.vertex_a_y) - ext_e(in_beat.vertex_c_y);
    item_c.e1_z    = ext_e(in_beat.vertex_a_z) - ext_e(in_beat.vertex_c_z);
    item_c.e2_x    = ext_e(in_beat.vertex_b_x) - ext_e(in_beat.vertex_c_x);
    item_c.e2_y    = ext_e(in_beat.vertex_b_y) - ext_e(in_beat.vertex_c_y);
    item_c.e2_z    = ext_e(in_beat.vertex_b_z) - ext_e(in_beat.vertex_c_z);
    item_c.s_x     = ext_e(ray.ray_origin_x) - ext_e(in_beat.vertex_c_x);
    item_c.s_y     = ext_e(ray.ray_origin_y) - ext_e(in_beat.vertex_c_y);
    item_c.s_z     = ext_e(ray.ray_origin_z) - ext_e(in_beat.vertex_c_z);
    item_c.new_ray = in_beat.new_ray;
  end

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem_r[rd_ptr_r];
  assign wr_en   = push && !full;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!wr_en && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= item_c;
    end
  end

endmodule

`default_nettype wire

>>> design/rtc_back.sv
`default_nettype none

module rtc_back #(
  parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rtc_pkg::ray_cfg_t  ray,
  input  wire logic               q_valid,
  input  wire rtc_pkg::edge_item_t q_item,
  output logic                    q_pop,
  input  wire logic               pop,
  output logic                    empty,
  output rtc_pkg::out_beat_t      out_beat
);
  import rtc_pkg::*;

  localparam int DW     = AW + FRAC_BITS;
  localparam int DCNT_W = $clog2(DW);
  localparam int BCNT_W = $clog2(EW);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_LOAD  = 8'b0000_0010,
    ST_MAC   = 8'b0000_0100,
    ST_NORM  = 8'b0000_1000,
    ST_CHECK = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_SAT   = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    out_valid_r, out_valid_nxt;
  coord_t                  far_r, far_nxt;
  out_beat_t               out_r;
  edge_item_t              item_r;
  logic [TERM_IDX_W-1:0]   term_r;
  logic [BCNT_W-1:0]       bcnt_r;
  logic [DCNT_W-1:0]       dcnt_r;
  acc_t                    mcand_r, acc_r;
  edge_t                   mplier_r;
  xop_t                    s1_r [3];
  xop_t                    s2_r [3];
  acc_t                    det_r, nt_r, nb1_r, nb2_r;
  logic                    cand_r, neg_r;
  logic [AW-1:0]           rem_r;
  logic [DW-1:0]           quo_r;
  coord_t                  t_r;

  mac_term_t               term;
  xop_t                    x_op;
  edge_t                   y_op;
  acc_t                    addend, acc_sum, nb_sum, mag;
  logic                    sub, bit_last, slot, hit_c, bary_c, over;
  logic [AW:0]             rem_sh, rem_diff;
  logic                    ge;
  coord_t                  q_low, t_c;

  always_comb begin
    term = mac_prog(term_r);
    case (term.xsel)
      XS_DIR_X: x_op = ext_x(ext_e(ray.ray_direction_x));
      XS_DIR_Y: x_op = ext_x(ext_e(ray.ray_direction_y));
      XS_DIR_Z: x_op = ext_x(ext_e(ray.ray_direction_z));
      XS_S_X:   x_op = ext_x(item_r.s_x);
      XS_S_Y:   x_op = ext_x(item_r.s_y);
      XS_S_Z:   x_op = ext_x(item_r.s_z);
      XS_S1_X:  x_op = s1_r[0];
      XS_S1_Y:  x_op = s1_r[1];
      XS_S1_Z:  x_op = s1_r[2];
      XS_S2_X:  x_op = s2_r[0];
      XS_S2_Y:  x_op = s2_r[1];
      XS_S2_Z:  x_op = s2_r[2];
      default:  x_op = '0;
    endcase
    case (term.ysel)
      YS_E1_X:  y_op = item_r.e1_x;
      YS_E1_Y:  y_op = item_r.e1_y;
      YS_E1_Z:  y_op = item_r.e1_z;
      YS_E2_X:  y_op = item_r.e2_x;
      YS_E2_Y:  y_op = item_r.e2_y;
      YS_E2_Z:  y_op = item_r.e2_z;
      YS_S_X:   y_op = item_r.s_x;
      YS_S_Y:   y_op = item_r.s_y;
      YS_S_Z:   y_op = item_r.s_z;
      YS_DIR_X: y_op = ext_e(ray.ray_direction_x);
      YS_DIR_Y: y_op = ext_e(ray.ray_direction_y);
      YS_DIR_Z: y_op = ext_e(ray.ray_direction_z);
      default:  y_op = '0;
    endcase
  end

  // Shift-add step: the multiplier's top bit carries negative weight.
  assign bit_last = (bcnt_r == BCNT_W'(EW - 1));
  assign addend   = mplier_r[0] ? mcand_r : '0;
  assign sub      = term.neg ^ bit_last;
  assign acc_sum  = sub ? acc_r - addend : acc_r + addend;

  assign nb_sum = nb1_r + nb2_r;
  assign bary_c = (det_r != '0) && !nb1_r[AW-1] && !nb2_r[AW-1] && (nb_sum <= det_r);
  assign mag    = nt_r[AW-1] ? -nt_r : nt_r;

  // Restoring division, one quotient bit per cycle.
  assign rem_sh   = {rem_r, quo_r[DW-1]};
  assign rem_diff = rem_sh - {1'b0, det_r};
  assign ge       = (rem_sh >= {1'b0, det_r});

  assign over  = |quo_r[DW-1:CW-1];
  assign q_low = quo_r[CW-1:0];
  always_comb begin
    if (neg_r) begin
      t_c = over ? COORD_MIN : -q_low;
    end else begin
      t_c = over ? COORD_MAX : q_low;
    end
  end

  assign slot  = !out_valid_r || pop;
  assign hit_c = cand_r && ($signed(t_r) >= $signed(ray.near_limit)) &&
                 ($signed(t_r) <= $signed(far_r));

  always_comb begin
    state_nxt     = state_r;
    far_nxt       = far_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    if (pop) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_LOAD;
          if (q_item.new_ray) begin
            far_nxt = ray.far_limit_start;
          end
        end
      end
      ST_LOAD: state_nxt = ST_MAC;
      ST_MAC: begin
        if (bit_last) begin
          state_nxt = (term_r == TERM_IDX_W'(NUM_TERMS - 1)) ? ST_NORM : ST_LOAD;
        end
      end
      ST_NORM:  state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = bary_c ? ST_DIV : ST_FIN;
      ST_DIV: begin
        if (dcnt_r == DCNT_W'(DW - 1)) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: state_nxt = ST_FIN;
      ST_FIN: begin
        if (slot) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (hit_c) begin
            far_nxt = t_r;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      far_r       <= COORD_MAX;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      far_r       <= far_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        item_r <= q_item;
        term_r <= '0;
        acc_r  <= '0;
      end
      ST_LOAD: begin
        mcand_r  <= ext_a(x_op);
        mplier_r <= y_op;
        bcnt_r   <= '0;
      end
      ST_MAC: begin
        mcand_r  <= {mcand_r[AW-2:0], 1'b0};
        mplier_r <= mplier_r >>> 1;
        bcnt_r   <= bcnt_r + 1'b1;
        acc_r    <= (bit_last && term.last) ? '0 : acc_sum;
        if (bit_last) begin
          term_r <= term_r + 1'b1;
          if (term.last) begin
            case (term.dst)
              DST_S1_X: s1_r[0] <= acc_sum[XW-1:0];
              DST_S1_Y: s1_r[1] <= acc_sum[XW-1:0];
              DST_S1_Z: s1_r[2] <= acc_sum[XW-1:0];
              DST_S2_X: s2_r[0] <= acc_sum[XW-1:0];
              DST_S2_Y: s2_r[1] <= acc_sum[XW-1:0];
              DST_S2_Z: s2_r[2] <= acc_sum[XW-1:0];
              DST_DET:  det_r   <= acc_sum;
              DST_NT:   nt_r    <= acc_sum;
              DST_NB1:  nb1_r   <= acc_sum;
              DST_NB2:  nb2_r   <= acc_sum;
              default: ;
            endcase
          end
        end
      end
      ST_NORM: begin
        // Flip signs so that the determinant is not negative.
        if (det_r[AW-1]) begin
          det_r <= -det_r;
          nt_r  <= -nt_r;
          nb1_r <= -nb1_r;
          nb2_r <= -nb2_r;
        end
      end
      ST_CHECK: begin
        cand_r <= bary_c;
        neg_r  <= nt_r[AW-1];
        rem_r  <= '0;
        quo_r  <= {mag, {FRAC_BITS{1'b0}}};
        dcnt_r <= '0;
      end
      ST_DIV: begin
        rem_r  <= ge ? rem_diff[AW-1:0] : rem_sh[AW-1:0];
        quo_r  <= {quo_r[DW-2:0], ge};
        dcnt_r <= dcnt_r + 1'b1;
      end
      ST_SAT: t_r <= t_c;
      ST_FIN: begin
        if (slot) begin
          out_r.hit              <= hit_c;
          out_r.hit_distance     <= hit_c ? t_r : '0;
          out_r.closest_distance <= hit_c ? t_r : far_r;
        end
      end
      default: ;
    endcase
  end

  assign empty    = !out_valid_r;
  assign out_beat = out_r;

endmodule

`default_nettype wire

>>> design/ray_triangle_closest_hit.sv
// Closest-hit ray/triangle test in Q16.16 fixed point.
// Configuration: write the ray (origin, direction, near limit, far start)
// through cfg_we / cfg_index / cfg_wdata while no triangle is in flight.
// Input: one triangle beat (three vertices, new_ray) is taken at an edge
// with push high and full low. new_ray reloads the running far bound.
// Output: a result beat (hit, hit_distance, closest_distance) waits on
// out_beat while empty is low and leaves at an edge with pop high.
// The front turns each beat into edge vectors combinationally and queues
// up to two of them; the back evaluates one triangle at a time with a
// single bit-serial multiply-accumulate unit (24 products of 33 multiplier
// bits, each after its own load step) and a one-bit-per-cycle restoring
// divider. The back finishes one triangle before it pops the next beat
// from the queue: load and multiply for each product, then normalize,
// check, divide and saturate, then finish; a miss on the barycentric
// test skips the divide and the saturation.
// If the result register is still held, the back waits with its finished
// result and the queue keeps taking beats until full.
// Reset empties queue and result, clears the ray and sets the far bound
// and far start to the largest positive value.
`default_nettype none
`include "ray_triangle_closest_hit_defines.svh"

module ray_triangle_closest_hit #(
  parameter int FRAC_BITS = rtc_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          push,
  output logic                               full,
  input  wire rtc_pkg::in_beat_t             in_beat,
  output logic                               empty,
  input  wire logic                          pop,
  output rtc_pkg::out_beat_t                 out_beat,
  input  wire logic                          cfg_we,
  input  wire logic [rtc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rtc_pkg::CW-1:0]        cfg_wdata
);
  import rtc_pkg::*;

  ray_cfg_t   ray_r;
  logic       q_valid, q_pop;
  edge_item_t q_item;

  // Far start sits in the low bits of the ray struct.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r <= {{(7*CW){1'b0}}, COORD_MAX};
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ORIGIN_X:    ray_r.ray_origin_x    <= cfg_wdata;
        REG_ORIGIN_Y:    ray_r.ray_origin_y    <= cfg_wdata;
        REG_ORIGIN_Z:    ray_r.ray_origin_z    <= cfg_wdata;
        REG_DIRECTION_X: ray_r.ray_direction_x <= cfg_wdata;
        REG_DIRECTION_Y: ray_r.ray_direction_y <= cfg_wdata;
        REG_DIRECTION_Z: ray_r.ray_direction_z <= cfg_wdata;
        REG_NEAR_LIMIT:  ray_r.near_limit      <= cfg_wdata;
        REG_FAR_START:   ray_r.far_limit_start <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rtc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_beat (in_beat),
    .ray     (ray_r),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_item  (q_item)
  );

  rtc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ray      (ray_r),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .pop      (pop),
    .empty    (empty),
    .out_beat (out_beat)
  );

  // A miss carries no distance.
  `RTC_ASSERT_NOW(a_miss_zero, !empty && !out_beat.hit, out_beat.hit_distance == '0, "miss with distance")
  // A hit becomes the new closest distance.
  `RTC_ASSERT_NOW(a_hit_closest, !empty && out_beat.hit, out_beat.closest_distance == out_beat.hit_distance, "hit not closest")
  // Reset leaves both sides open.
  `RTC_ASSERT_AFTER(a_reset_open, !rst_n, empty && !full, "not open after reset")

endmodule

`default_nettype wire

>>> tb/tb_ray_triangle_closest_hit.sv
`default_nettype none

module tb_ray_triangle_closest_hit;
  import rtc_pkg::*;

  localparam int STALL_LIMIT = 8000;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  in_beat_t in_beat;
  logic empty;
  logic pop;
  out_beat_t out_beat;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_wdata;

  ray_triangle_closest_hit DUT (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .in_beat(in_beat),
    .empty(empty), .pop(pop), .out_beat(out_beat),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Local copy of the ray and the running far bound.
  coord_t ray_org [3];
  coord_t ray_dir [3];
  coord_t near_lim;
  coord_t far_start;
  coord_t far_bound = COORD_MAX;

  in_beat_t  tri_pending[$];
  out_beat_t hits_expected[$];
  int        err_count;
  bit        no_idle;
  int        push_gap;
  int        pop_gap;
  int        stall_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Exact Moller-Trumbore with edges from vertex c; 128 bits hold every
  // product and the shifted numerator without wrapping.
  function automatic out_beat_t predict_hit(input in_beat_t b);
    logic signed [127:0] e1 [3];
    logic signed [127:0] e2 [3];
    logic signed [127:0] sv [3];
    logic signed [127:0] dv [3];
    logic signed [127:0] s1 [3];
    logic signed [127:0] s2 [3];
    logic signed [127:0] det, nt, nb1, nb2, mag, quo;
    coord_t    t;
    out_beat_t r;
    if (b.new_ray) far_bound = far_start;
    e1[0] = b.vertex_a_x - b.vertex_c_x;
    e1[1] = b.vertex_a_y - b.vertex_c_y;
    e1[2] = b.vertex_a_z - b.vertex_c_z;
    e2[0] = b.vertex_b_x - b.vertex_c_x;
    e2[1] = b.vertex_b_y - b.vertex_c_y;
    e2[2] = b.vertex_b_z - b.vertex_c_z;
    sv[0] = ray_org[0] - b.vertex_c_x;
    sv[1] = ray_org[1] - b.vertex_c_y;
    sv[2] = ray_org[2] - b.vertex_c_z;
    for (int k = 0; k < 3; k++) dv[k] = ray_dir[k];
    s1[0] = dv[1] * e2[2] - dv[2] * e2[1];
    s1[1] = dv[2] * e2[0] - dv[0] * e2[2];
    s1[2] = dv[0] * e2[1] - dv[1] * e2[0];
    s2[0] = sv[1] * e1[2] - sv[2] * e1[1];
    s2[1] = sv[2] * e1[0] - sv[0] * e1[2];
    s2[2] = sv[0] * e1[1] - sv[1] * e1[0];
    det = s1[0] * e1[0] + s1[1] * e1[1] + s1[2] * e1[2];
    nt  = s2[0] * e2[0] + s2[1] * e2[1] + s2[2] * e2[2];
    nb1 = s1[0] * sv[0] + s1[1] * sv[1] + s1[2] * sv[2];
    nb2 = s2[0] * dv[0] + s2[1] * dv[1] + s2[2] * dv[2];
    r = '0;
    if (det != 0) begin
      if (det < 0) begin
        det = -det; nt = -nt; nb1 = -nb1; nb2 = -nb2;
      end
      if (nb1 >= 0 && nb2 >= 0 && nb1 + nb2 <= det) begin
        mag = (nt < 0) ? -nt : nt;
        quo = (mag <<< 16) / det;
        // Saturate the quotient to the coordinate range.
        if (nt < 0)
          t = (quo >= 128'sh8000_0000) ? COORD_MIN : coord_t'(-quo);
        else
          t = (quo >= 128'sh7FFF_FFFF) ? COORD_MAX : coord_t'(quo);
        if (t >= near_lim && t <= far_bound) begin
          r.hit = 1'b1;
          r.hit_distance = t;
          far_bound = t;
        end
      end
    end
    r.closest_distance = far_bound;
    return r;
  endfunction

  // Triangle centered on origin + dir * k, so it is hit at t = k unless
  // the limits say otherwise.
  function automatic in_beat_t build_hit(input int k, input bit nr);
    in_beat_t b;
    coord_t   p [3];
    int       u [3];
    int       v [3];
    for (int i = 0; i < 3; i++) begin
      p[i] = ray_org[i] + ray_dir[i] * k;
      u[i] = int'($urandom_range(0, 1 << 21)) - (1 << 20);
      v[i] = int'($urandom_range(0, 1 << 21)) - (1 << 20);
    end
    b.vertex_a_x = p[0] + u[0]; b.vertex_a_y = p[1] + u[1]; b.vertex_a_z = p[2] + u[2];
    b.vertex_b_x = p[0] + v[0]; b.vertex_b_y = p[1] + v[1]; b.vertex_b_z = p[2] + v[2];
    b.vertex_c_x = p[0] - u[0] - v[0];
    b.vertex_c_y = p[1] - u[1] - v[1];
    b.vertex_c_z = p[2] - u[2] - v[2];
    b.new_ray = nr;
    return b;
  endfunction

  function automatic in_beat_t random_tri();
    in_beat_t b;
    b = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
         $urandom(), $urandom(), $urandom(), $urandom(), 1'($urandom())};
    return b;
  endfunction

  function automatic in_beat_t flat_tri(input coord_t v, input bit nr);
    in_beat_t b;
    b = {v, v, v, v, v, v, v, v, v, nr};
    return b;
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input coord_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_ORIGIN_X:    ray_org[0] = val;
      REG_ORIGIN_Y:    ray_org[1] = val;
      REG_ORIGIN_Z:    ray_org[2] = val;
      REG_DIRECTION_X: ray_dir[0] = val;
      REG_DIRECTION_Y: ray_dir[1] = val;
      REG_DIRECTION_Z: ray_dir[2] = val;
      REG_NEAR_LIMIT:  near_lim   = val;
      REG_FAR_START:   far_start  = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_ray(input coord_t ox, input coord_t oy, input coord_t oz,
                         input coord_t dx, input coord_t dy, input coord_t dz,
                         input coord_t nl, input coord_t fs);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIRECTION_X, dx);
    write_reg(REG_DIRECTION_Y, dy);
    write_reg(REG_DIRECTION_Z, dz);
    write_reg(REG_NEAR_LIMIT, nl);
    write_reg(REG_FAR_START, fs);
  endtask

  function automatic coord_t small_val(input int span);
    return coord_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Wait until the block has drained: nothing queued, nothing in flight.
  // Sample at the falling edge so the sender's updates have settled.
  task automatic drain();
    while (tri_pending.size() != 0 || push || hits_expected.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Well-formed hits with random depth at hit_pct percent, the rest raw noise.
  task automatic queue_mix(input int n, input int hit_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < hit_pct)
        tri_pending.push_back(build_hit(int'($urandom_range(0, 12)) - 2,
                                        $urandom_range(0, 7) == 0));
      else
        tri_pending.push_back(random_tri());
    end
  endtask

  // Sender: hold the beat while full, otherwise advance or idle.
  always @(posedge clk) begin
    if (!rst_n) begin
      push     <= 1'b0;
      in_beat  <= '0;
      push_gap <= 0;
    end else begin
      if (push && !full) hits_expected.push_back(predict_hit(in_beat));
      if (!(push && full)) begin
        if (push_gap > 0) begin
          push_gap <= push_gap - 1;
          push     <= 1'b0;
        end else if (tri_pending.size() != 0) begin
          in_beat <= tri_pending.pop_front();
          push    <= 1'b1;
          if (!no_idle && $urandom_range(0, 9) == 0)
            push_gap <= $urandom_range(1, 18);
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted beat, then drop pop for random bursts.
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      pop     <= 1'b0;
      pop_gap <= 0;
    end else begin
      if (pop && !empty) begin
        if (hits_expected.size() == 0) begin
          $error("result beat with nothing expected");
          err_count++;
        end else begin
          want = hits_expected.pop_front();
          if (out_beat.hit !== want.hit) begin
            $error("hit: expected %0d, got %0d", want.hit, out_beat.hit);
            err_count++;
          end
          if (out_beat.hit_distance !== want.hit_distance) begin
            $error("hit_distance: expected %0d, got %0d",
                   want.hit_distance, out_beat.hit_distance);
            err_count++;
          end
          if (out_beat.closest_distance !== want.closest_distance) begin
            $error("closest_distance: expected %0d, got %0d",
                   want.closest_distance, out_beat.closest_distance);
            err_count++;
          end
        end
      end
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop     <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!no_idle && $urandom_range(0, 9) == 0)
          pop_gap <= $urandom_range(1, 18);
      end
    end
  end

  // Watchdog: the back end can hold off acceptance while it works on a
  // triangle; a stall that reaches STALL_LIMIT is taken as a hang.
  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    no_idle   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ray_org[i] = '0;
      ray_dir[i] = '0;
    end
    near_lim  = '0;
    far_start = COORD_MAX;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset ray: zero direction, so every determinant is zero.
    tri_pending.push_back(flat_tri('0, 1'b0));
    tri_pending.push_back(flat_tri(COORD_MAX, 1'b1));
    tri_pending.push_back(flat_tri(COORD_MIN, 1'b0));
    tri_pending.push_back(random_tri());
    drain();

    // Small ray: hits at several depths, repeat hit at equal distance,
    // behind-origin hit, degenerate triangle.
    set_ray(small_val(1 << 24), small_val(1 << 24), small_val(1 << 24),
            small_val(1 << 18), small_val(1 << 18), small_val(1 << 18),
            '0, COORD_MAX);
    tri_pending.push_back(build_hit(4, 1'b1));
    tri_pending.push_back(build_hit(6, 1'b0));
    tri_pending.push_back(build_hit(2, 1'b0));
    tri_pending.push_back(build_hit(2, 1'b0));
    tri_pending.push_back(build_hit(-2, 1'b0));
    tri_pending.push_back(flat_tri(ray_org[0], 1'b0));
    tri_pending.push_back(build_hit(1, 1'b1));
    tri_pending.push_back(build_hit(0, 1'b1));
    drain();
    queue_mix(140, 75);
    drain();

    // Narrow window between near and far start.
    set_ray(small_val(1 << 20), small_val(1 << 20), small_val(1 << 20),
            small_val(1 << 17), small_val(1 << 17), small_val(1 << 17),
            coord_t'(3 << 16), coord_t'(6 << 16));
    queue_mix(140, 80);
    drain();

    // Extreme rays, full-range triangles.
    set_ray(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
            COORD_MIN, COORD_MAX);
    tri_pending.push_back(flat_tri(COORD_MAX, 1'b1));
    tri_pending.push_back(random_tri());
    queue_mix(100, 0);
    drain();
    set_ray(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
            COORD_MAX, COORD_MIN);
    queue_mix(100, 0);
    drain();

    // Random full-bit ray with a tiny direction drives the saturation path.
    set_ray(coord_t'($urandom()), coord_t'($urandom()), coord_t'($urandom()),
            coord_t'(1), coord_t'(-1), coord_t'(2), COORD_MIN, COORD_MAX);
    queue_mix(80, 0);
    drain();

    // Inverted limits: nothing may hit.
    set_ray(small_val(1 << 22), small_val(1 << 22), small_val(1 << 22),
            small_val(1 << 18), small_val(1 << 18), small_val(1 << 18),
            coord_t'(10 << 16), coord_t'(2 << 16));
    queue_mix(80, 80);
    drain();

    // Closing stretch with no idling on either side.
    set_ray(small_val(1 << 24), small_val(1 << 24), small_val(1 << 24),
            small_val(1 << 18), small_val(1 << 18), small_val(1 << 18),
            '0, COORD_MAX);
    no_idle = 1'b1;
    queue_mix(150, 75);
    drain();
    repeat (20) @(posedge clk);

    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
